[design/apsp_pkg.sv]
// ----------------------------------------------------------------------------
// apsp_pkg
// types and constants of the all-pairs shortest path block
// ----------------------------------------------------------------------------
package apsp_pkg;

  // node index width of the item fields
  localparam int NODE_W = 3;
  // width of the node count register
  localparam int CNT_W = 4;
  // edge weight and stored distance widths
  localparam int WGT_W = 16;
  localparam int DIST_W = 32;

  // saturation bounds of the distance range, one bit wider for the raw sum
  localparam logic signed [DIST_W:0] SUM_MAX = 33'sd2147483646;
  localparam logic signed [DIST_W:0] SUM_MIN = -33'sd2147483647;

  // reset value of the node count register
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 4'd8;

  typedef enum logic [3:0] {
    ST_LOAD,     // taking edges
    ST_DIAG,     // forcing the diagonal to zero
    ST_IK_RD,    // read d[i][k] for the next row
    ST_IK_CAP,   // capture d[i][k]
    ST_RX_RD,    // read d[k][j] and d[i][j]
    ST_RX_EX,    // relax and write back d[i][j]
    ST_EM_RD,    // read one matrix entry for output
    ST_EM_OUT,   // present one matrix entry
    ST_NEG_OUT   // present the negative cycle report
  } apsp_state_t;

endpackage

[design/all_pairs_shortest_path.sv]
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// floyd-warshall all-pairs shortest path over a distance matrix memory
// ----------------------------------------------------------------------------
// Edges load one item per cycle into a MAX_NODES x MAX_NODES distance memory
// (one write port, two registered read ports) with one valid flip-flop per
// entry; an entry that is not valid reads as infinite. The item with tlast
// set starts the run and the input stays stalled until the run's last result
// is taken. With n the node count in use, the run zeroes the diagonal, fetches
// d[i][k] at the start of each row and relaxes every entry of the row with a
// read state and a write-back state, once for each k; it then emits each entry
// with a read state and an output state that is held by any output stall.
// A negative cycle gives one report item instead of the matrix. All valid bits
// clear in the cycle the last result is taken, so no clearing pass is needed
// and the next edge is taken the following cycle.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path
  import apsp_pkg::*;
#(
  parameter int MAX_NODES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: node_count
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // edge items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // source_node[2:0], dest_node[5:3], edge_weight[21:6]
  input  logic        in_tuser,   // has_edge
  input  logic        in_tlast,   // last_edge
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // row_node[2:0], col_node[5:3], distance[37:6]
  output logic [1:0]  out_tuser,  // unreachable[0], negative_cycle[1]
  output logic        out_tlast   // last_result
);

  // node index width inside the block, address is {row, col}
  localparam int IW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 2 ** AW;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  apsp_state_t state_r, state_nxt;

  logic [CNT_W-1:0] node_count_r;
  logic [IW-1:0]    last_idx_r, last_idx_nxt;   // n - 1 of the current run
  logic [IW-1:0]    i_r, i_nxt;
  logic [IW-1:0]    j_r, j_nxt;
  logic [IW-1:0]    k_r, k_nxt;
  logic             neg_r, neg_nxt;             // a diagonal went negative
  logic [DIST_W-1:0] ik_r, ik_nxt;              // d[i][k] held over one row
  logic             ik_v_r, ik_v_nxt;

  // distance memory and its valid bits (valid means finite)
  logic [DIST_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DIST_W-1:0] rd_a_r, rd_b_r;
  logic              rv_a_r, rv_b_r;

  // memory control from the sequencer
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DIST_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     ra_a, ra_b;
  logic              clear_all;

  // ---------------------------------------------------------------------------
  // input fields
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0] in_src, in_dst;
  logic [WGT_W-1:0]  in_wgt;
  logic              in_acc;
  logic              edge_ok;

  assign in_src = in_tdata[2:0];
  assign in_dst = in_tdata[5:3];
  assign in_wgt = in_tdata[21:6];
  assign in_acc = in_tvalid && in_tready;

  // edges indexing past the matrix are dropped
  assign edge_ok = in_tuser
                && ({1'b0, in_src} < CNT_W'(MAX_NODES))
                && ({1'b0, in_dst} < CNT_W'(MAX_NODES));

  // ---------------------------------------------------------------------------
  // relaxation datapath: s = sat(d[i][k] + d[k][j]), replace if smaller
  // ---------------------------------------------------------------------------
  logic signed [DIST_W:0]   raw_sum;
  logic signed [DIST_W-1:0] sat_sum;
  logic                     relax_upd;

  assign raw_sum = $signed({ik_r[DIST_W-1], ik_r}) + $signed({rd_a_r[DIST_W-1], rd_a_r});

  always_comb begin
    if (raw_sum > SUM_MAX) begin
      sat_sum = SUM_MAX[DIST_W-1:0];
    end else if (raw_sum < SUM_MIN) begin
      sat_sum = SUM_MIN[DIST_W-1:0];
    end else begin
      sat_sum = raw_sum[DIST_W-1:0];
    end
  end

  // both operands finite, and the target infinite or larger
  assign relax_upd = ik_v_r && rv_a_r && (!rv_b_r || (sat_sum < $signed(rd_b_r)));

  logic i_last, j_last, k_last;
  assign i_last = (i_r == last_idx_r);
  assign j_last = (j_r == last_idx_r);
  assign k_last = (k_r == last_idx_r);

  // ---------------------------------------------------------------------------
  // state register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      node_count_r <= NODE_COUNT_RST;
      neg_r        <= 1'b0;
      last_idx_r   <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      ik_v_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      neg_r      <= neg_nxt;
      last_idx_r <= last_idx_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      ik_v_r     <= ik_v_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ik_r <= ik_nxt;
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state, counters and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    last_idx_nxt = last_idx_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    neg_nxt      = neg_r;
    ik_nxt       = ik_r;
    ik_v_nxt     = ik_v_r;
    mem_we       = 1'b0;
    mem_wa       = {i_r, j_r};
    mem_wd       = '0;
    mem_re       = 1'b0;
    ra_a         = {k_r, j_r};
    ra_b         = {i_r, j_r};
    clear_all    = 1'b0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;

    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_acc && edge_ok) begin
          mem_we = 1'b1;
          mem_wa = {in_src[IW-1:0], in_dst[IW-1:0]};
          mem_wd = {{(DIST_W-WGT_W){in_wgt[WGT_W-1]}}, in_wgt};
        end
        if (in_acc && in_tlast) begin
          // clamp the node count to 1..MAX_NODES
          if (node_count_r == '0) begin
            last_idx_nxt = '0;
          end else if (node_count_r > CNT_W'(MAX_NODES)) begin
            last_idx_nxt = IW'(MAX_NODES - 1);
          end else begin
            last_idx_nxt = IW'(node_count_r - CNT_W'(1));
          end
          i_nxt     = '0;
          neg_nxt   = 1'b0;
          state_nxt = ST_DIAG;
        end
      end

      ST_DIAG: begin
        mem_we = 1'b1;
        mem_wa = {i_r, i_r};
        mem_wd = '0;
        if (i_last) begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_IK_RD;
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end

      ST_IK_RD: begin
        mem_re    = 1'b1;
        ra_a      = {i_r, k_r};
        state_nxt = ST_IK_CAP;
      end

      ST_IK_CAP: begin
        ik_nxt    = rd_a_r;
        ik_v_nxt  = rv_a_r;
        j_nxt     = '0;
        state_nxt = ST_RX_RD;
      end

      ST_RX_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_RX_EX;
      end

      ST_RX_EX: begin
        if (relax_upd) begin
          mem_we = 1'b1;
          mem_wd = sat_sum;
          // d[i][k] itself changed: later columns of this row see it
          if (j_r == k_r) begin
            ik_nxt = sat_sum;
          end
          // diagonals only decrease, so a negative write is final
          if ((i_r == j_r) && sat_sum[DIST_W-1]) begin
            neg_nxt = 1'b1;
          end
        end
        if (!j_last) begin
          j_nxt     = j_r + IW'(1);
          state_nxt = ST_RX_RD;
        end else begin
          j_nxt = '0;
          if (!i_last) begin
            i_nxt     = i_r + IW'(1);
            state_nxt = ST_IK_RD;
          end else begin
            i_nxt = '0;
            if (!k_last) begin
              k_nxt     = k_r + IW'(1);
              state_nxt = ST_IK_RD;
            end else if (neg_nxt) begin
              state_nxt = ST_NEG_OUT;
            end else begin
              state_nxt = ST_EM_RD;
            end
          end
        end
      end

      ST_EM_RD: begin
        mem_re    = 1'b1;
        ra_a      = {i_r, j_r};
        state_nxt = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (i_last && j_last) begin
            clear_all = 1'b1;
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_LOAD;
          end else if (j_last) begin
            j_nxt     = '0;
            i_nxt     = i_r + IW'(1);
            state_nxt = ST_EM_RD;
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end

      ST_NEG_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          clear_all = 1'b1;
          state_nxt = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // distance memory: one write port, two registered read ports
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_a_r <= mem[ra_a];
      rd_b_r <= mem[ra_b];
    end
  end

  // finite flags: reset and the end of a run make every entry infinite
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rv_a_r  <= 1'b0;
      rv_b_r  <= 1'b0;
    end else begin
      if (clear_all) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rv_a_r <= valid_r[ra_a];
        rv_b_r <= valid_r[ra_b];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result item
  // ---------------------------------------------------------------------------
  logic              is_neg;
  logic [DIST_W-1:0] out_dist;

  assign is_neg   = (state_r == ST_NEG_OUT);
  assign out_dist = (rv_a_r && !is_neg) ? rd_a_r : '0;

  assign out_tdata = {2'b00, out_dist,
                      is_neg ? NODE_W'(0) : NODE_W'(j_r),
                      is_neg ? NODE_W'(0) : NODE_W'(i_r)};
  assign out_tuser = {is_neg, !is_neg && !rv_a_r};
  assign out_tlast = is_neg || (i_last && j_last);

`ifndef SYNTHESIS
  // input and output sides never run at the same time
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is offered");

  // the last edge stalls the input for the whole run
  a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input taken right after the last edge");

  // the matrix is not written while results are offered
  a_no_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !mem_we)
    else $error("matrix written during emission");

  // a negative cycle report comes only from a negative diagonal
  a_neg_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> neg_r)
    else $error("negative cycle report without a negative diagonal");
`endif

endmodule
